// ----- hw/rtl/fft_bin_magnitude_fast_rsqrt_unit_defines.svh -----
// Assertion macros for the FFT bin magnitude unit checker.
// No dependencies; included by the checker file.
`ifndef FFT_BIN_MAGNITUDE_FAST_RSQRT_UNIT_DEFINES_SVH
`define FFT_BIN_MAGNITUDE_FAST_RSQRT_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define RSQ_CHK_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rsq check failed");

// condition must never hold
`define RSQ_CHK_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("rsq check failed");

`endif

// ----- hw/rtl/rsq_pkg.sv -----
// Shared types, constants and float helpers for the FFT bin magnitude unit.
// No dependencies.
package rsq_pkg;

   localparam logic [31:0] MAGIC_RSQRT = 32'h5f3759df;
   localparam logic [31:0] FP_ONE_HALF = 32'h3fc00000; // 1.5
   localparam int          LATENCY     = 20;

   typedef struct packed {
      logic [31:0] s;
      logic [31:0] half;
      logic [31:0] y;
   } ctx_type;

   // leading zero count of a nonzero word
   function automatic logic [4:0] lzc32(input logic [31:0] v);
      logic [4:0] lz;
      lz = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) lz = 5'(31 - i);
      end
      return lz;
   endfunction

   // unsigned integer to single precision, round to nearest even
   function automatic logic [31:0] int_to_fp(input logic [31:0] v);
      logic [4:0]  lz;
      logic [31:0] n;
      logic        inc;
      logic [23:0] mr;
      logic [7:0]  e;
      lz  = lzc32(v);
      n   = v << lz;
      inc = n[7] & ((|n[6:0]) | n[8]);
      mr  = {1'b0, n[30:8]} + {23'd0, inc};
      e   = 8'd158 - {3'd0, lz} + {7'd0, mr[23]};
      if (v == 32'd0) return 32'd0;
      return {1'b0, e, mr[22:0]};
   endfunction

   // integer-valued float (below 2^31) back to integer
   function automatic logic [31:0] fp_to_int(input logic [31:0] f);
      logic [31:0] val;
      val = {8'd0, 1'b1, f[22:0]};
      if (f[30:23] == 8'd0) return 32'd0;
      if (f[30:23] >= 8'd150) return val << (f[30:23] - 8'd150);
      return val >> (8'd150 - f[30:23]);
   endfunction

endpackage

// ----- hw/rtl/fft_bin_magnitude_fast_rsqrt_unit.sv -----
// Magnitude of one packed FFT bin via fast inverse square root.
// One beat per cycle from accepted start to rsp_valid.
// The chain: 4 front stages, 2 Newton steps of 7, final multiply 2.
// busy is always low; the result shows for one cycle and cannot be stalled.
// Synchronous reset clears all valid bits; data registers are not reset.
module fft_bin_magnitude_fast_rsqrt_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_packed_bin,
   output logic        rsp_valid,
   output logic [31:0] rsp_magnitude_bits
);
   logic             fv, n1v, n2v;
   rsq_pkg::ctx_type fc, n1c, n2c, mc;

   assign busy = 1'b0;

   rsq_front  u_front (.clock, .reset, .in_valid(start), .packed_bin(req_packed_bin),
                       .out_valid(fv), .out_ctx(fc));
   rsq_newton u_nt1   (.clock, .reset, .in_valid(fv), .in_ctx(fc),
                       .out_valid(n1v), .out_ctx(n1c));
   rsq_newton u_nt2   (.clock, .reset, .in_valid(n1v), .in_ctx(n1c),
                       .out_valid(n2v), .out_ctx(n2c));
   rsq_fmul   u_fin   (.clock, .reset, .in_valid(n2v), .a(n2c.s), .b(n2c.y),
                       .in_ctx(n2c), .out_valid(rsp_valid), .p(rsp_magnitude_bits),
                       .out_ctx(mc));
endmodule

// ----- hw/rtl/rsq_fmul.sv -----
// Two-stage single precision multiplier for nonnegative normal or zero operands.
// Carries a context word alongside. Depends on rsq_pkg.
module rsq_fmul (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [31:0]      a,
   input  logic [31:0]      b,
   input  rsq_pkg::ctx_type in_ctx,
   output logic             out_valid,
   output logic [31:0]      p,
   output rsq_pkg::ctx_type out_ctx
);
   logic             v1_ff, v2_ff;
   logic             zero_ff, zero_in;
   logic [9:0]       esum_ff, esum_in;
   logic [47:0]      prod_ff, prod_in;
   rsq_pkg::ctx_type ctx1_ff, ctx2_ff;
   logic [31:0]      p_ff, p_in;

   logic [22:0] mant;
   logic        g, st, inc;
   logic [23:0] mr;
   logic [9:0]  e;

   always_comb begin
      zero_in = (a[30:23] == 8'd0) || (b[30:23] == 8'd0);
      esum_in = {2'd0, a[30:23]} + {2'd0, b[30:23]};
      prod_in = {1'b1, a[22:0]} * {1'b1, b[22:0]};
   end

   always_comb begin
      if (prod_ff[47]) begin
         mant = prod_ff[46:24];
         g    = prod_ff[23];
         st   = |prod_ff[22:0];
      end else begin
         mant = prod_ff[45:23];
         g    = prod_ff[22];
         st   = |prod_ff[21:0];
      end
      inc  = g & (st | mant[0]);
      mr   = {1'b0, mant} + {23'd0, inc};
      e    = esum_ff - 10'd127 + {9'd0, prod_ff[47]} + {9'd0, mr[23]};
      p_in = zero_ff ? 32'd0 : {1'b0, e[7:0], mr[22:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      zero_ff <= zero_in;
      esum_ff <= esum_in;
      prod_ff <= prod_in;
      ctx1_ff <= in_ctx;
      p_ff    <= p_in;
      ctx2_ff <= ctx1_ff;
   end

   assign out_valid = v2_ff;
   assign p         = p_ff;
   assign out_ctx   = ctx2_ff;
endmodule

// ----- hw/rtl/rsq_sub.sv -----
// One-stage 1.5 - t subtractor, t nonnegative and below 1.5, round to nearest even.
// Depends on rsq_pkg.
module rsq_sub (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [31:0]      t,
   input  rsq_pkg::ctx_type in_ctx,
   output logic             out_valid,
   output logic [31:0]      r,
   output rsq_pkg::ctx_type out_ctx
);
   logic             v_ff;
   logic [31:0]      r_ff, r_in;
   rsq_pkg::ctx_type ctx_ff;

   logic [7:0]  d;
   logic [5:0]  sh;
   logic [49:0] wide;
   logic [26:0] bx, diff, norm;
   logic [4:0]  lz;
   logic        inc;
   logic [23:0] mr;
   logic [7:0]  e;

   always_comb begin
      d    = 8'd127 - t[30:23];
      sh   = (d > 8'd49) ? 6'd49 : d[5:0];
      wide = {1'b1, t[22:0], 26'd0} >> sh;
      bx   = {wide[49:24], |wide[23:0]};
      diff = {24'hc00000, 3'd0} - bx;
      lz   = rsq_pkg::lzc32({diff, 5'd0});
      norm = diff << lz;
      inc  = norm[2] & ((|norm[1:0]) | norm[3]);
      mr   = {1'b0, norm[25:3]} + {23'd0, inc};
      e    = 8'd127 - {3'd0, lz} + {7'd0, mr[23]};
      r_in = (t[30:23] == 8'd0) ? rsq_pkg::FP_ONE_HALF : {1'b0, e, mr[22:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= in_valid;
      end
      r_ff   <= r_in;
      ctx_ff <= in_ctx;
   end

   assign out_valid = v_ff;
   assign r         = r_ff;
   assign out_ctx   = ctx_ff;
endmodule

// ----- hw/rtl/rsq_newton.sv -----
// One Newton refinement y = y * (1.5 - (half*y)*y), seven stages.
// Depends on rsq_pkg, rsq_fmul, rsq_sub.
module rsq_newton (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  rsq_pkg::ctx_type in_ctx,
   output logic             out_valid,
   output rsq_pkg::ctx_type out_ctx
);
   logic             v1, v2, v3, v4;
   logic [31:0]      t1, t2, t3, yn;
   rsq_pkg::ctx_type c1, c2, c3, c4;

   rsq_fmul u_m1 (.clock, .reset, .in_valid(in_valid), .a(in_ctx.half), .b(in_ctx.y),
                  .in_ctx(in_ctx), .out_valid(v1), .p(t1), .out_ctx(c1));
   rsq_fmul u_m2 (.clock, .reset, .in_valid(v1), .a(t1), .b(c1.y),
                  .in_ctx(c1), .out_valid(v2), .p(t2), .out_ctx(c2));
   rsq_sub  u_s  (.clock, .reset, .in_valid(v2), .t(t2),
                  .in_ctx(c2), .out_valid(v3), .r(t3), .out_ctx(c3));
   rsq_fmul u_m3 (.clock, .reset, .in_valid(v3), .a(c3.y), .b(t3),
                  .in_ctx(c3), .out_valid(v4), .p(yn), .out_ctx(c4));

   always_comb begin
      out_ctx   = c4;
      out_ctx.y = yn;
   end
   assign out_valid = v4;
endmodule

// ----- hw/rtl/rsq_front.sv -----
// Front end: squares, per-square rounding, sum, conversion and first estimate.
// Four stages. Depends on rsq_pkg.
module rsq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [31:0]      packed_bin,
   output logic             out_valid,
   output rsq_pkg::ctx_type out_ctx
);
   logic [3:0]       v_ff;
   logic [31:0]      xsq_ff, ysq_ff, xsq_in, ysq_in;
   logic [31:0]      xf_ff, yf_ff;
   logic [31:0]      sum_ff, sum_in;
   rsq_pkg::ctx_type ctx_ff, ctx_in;
   logic [31:0]      s;

   always_comb begin
      xsq_in = 32'($signed(packed_bin[15:0]) * $signed(packed_bin[15:0]));
      ysq_in = 32'($signed(packed_bin[31:16]) * $signed(packed_bin[31:16]));
      // float add of two integer-valued floats: exact integer sum, one rounding
      sum_in = rsq_pkg::fp_to_int(xf_ff) + rsq_pkg::fp_to_int(yf_ff);
      s           = rsq_pkg::int_to_fp(sum_ff);
      ctx_in.s    = s;
      ctx_in.half = (s == 32'd0) ? 32'd0 : s - 32'h00800000;
      ctx_in.y    = rsq_pkg::MAGIC_RSQRT - {1'b0, s[31:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 4'd0;
      end else begin
         v_ff <= {v_ff[2:0], in_valid};
      end
      xsq_ff <= xsq_in;
      ysq_ff <= ysq_in;
      xf_ff  <= rsq_pkg::int_to_fp(xsq_ff);
      yf_ff  <= rsq_pkg::int_to_fp(ysq_ff);
      sum_ff <= sum_in;
      ctx_ff <= ctx_in;
   end

   assign out_valid = v_ff[3];
   assign out_ctx   = ctx_ff;
endmodule

// ----- hw/rtl/rsq_checker.sv -----
// Port-level checker for the FFT bin magnitude unit, bound to the top level.
// Depends on rsq_pkg and the defines header.
`include "fft_bin_magnitude_fast_rsqrt_unit_defines.svh"

module rsq_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [31:0] req_packed_bin,
   input logic        rsp_valid,
   input logic [31:0] rsp_magnitude_bits
);
   `RSQ_CHK_NEVER(a_never_busy, busy)
   `RSQ_CHK_IMPL(a_no_stray_beat, rsp_valid, $past(start, rsq_pkg::LATENCY))
   `RSQ_CHK_IMPL(a_sign_clear, rsp_valid, !rsp_magnitude_bits[31])
   `RSQ_CHK_IMPL(a_zero_bin,
                 rsp_valid && $past(req_packed_bin == 32'd0, rsq_pkg::LATENCY),
                 rsp_magnitude_bits == 32'd0)
endmodule

bind fft_bin_magnitude_fast_rsqrt_unit rsq_checker u_rsq_checker (.*);

// ----- dv/fft_bin_magnitude_fast_rsqrt_unit_checker.sv -----
// Checker for the FFT bin magnitude unit: watches request and response beats,
// predicts each magnitude with a single-precision model and compares in order.
// Depends on rsq_pkg and the DUT port list.
module fft_bin_magnitude_fast_rsqrt_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [31:0] req_packed_bin,
   input  logic        rsp_valid,
   input  logic [31:0] rsp_magnitude_bits,
   output int          errors,
   output int          pending
);

   logic [31:0] magnitude_q[$];

   // single-precision bits to real (normals and zero only)
   function automatic real sp_to_real(input logic [31:0] f);
      logic [63:0] d;
      if (f[30:0] == 31'd0) return 0.0;
      d = {f[31], 11'(f[30:23]) - 11'd127 + 11'd1023, f[22:0], 29'd0};
      return $bitstoreal(d);
   endfunction

   // real to single precision, round to nearest even; range stays normal here
   function automatic logic [31:0] real_to_sp(input real r);
      logic [63:0] d;
      logic [24:0] m;
      logic [7:0]  e;
      logic        inc;
      d = $realtobits(r);
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      e   = 8'(d[62:52] - 11'd1023 + 11'd127);
      inc = d[28] & ((|d[27:0]) | d[29]);
      m   = {2'b01, d[51:29]} + {24'd0, inc};
      if (m[24]) begin
         e = e + 8'd1;
         m = m >> 1;
      end
      return {d[63], e, m[22:0]};
   endfunction

   // each op is exact in double, then rounded once to single
   function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
      return real_to_sp(sp_to_real(a) * sp_to_real(b));
   endfunction

   function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
      return real_to_sp(sp_to_real(a) + sp_to_real(b));
   endfunction

   function automatic logic [31:0] rsqrt_refine(input logic [31:0] y, input logic [31:0] h);
      logic [31:0] t;
      t = sp_mul(sp_mul(h, y), y);
      t = sp_add(rsq_pkg::FP_ONE_HALF, t ^ 32'h8000_0000);
      return sp_mul(y, t);
   endfunction

   function automatic logic [31:0] bin_magnitude(input logic [31:0] w);
      logic [31:0] re, im, s, h, y;
      re = real_to_sp(real'($signed(w[15:0])));
      im = real_to_sp(real'($signed(w[31:16])));
      s  = sp_add(sp_mul(re, re), sp_mul(im, im));
      h  = sp_mul(s, 32'h3f00_0000);
      y  = rsq_pkg::MAGIC_RSQRT - (s >> 1);
      y  = rsqrt_refine(y, h);
      y  = rsqrt_refine(y, h);
      return sp_mul(s, y);
   endfunction

   assign pending = magnitude_q.size();

   initial errors = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) magnitude_q.push_back(bin_magnitude(req_packed_bin));
         if (rsp_valid) begin
            if (magnitude_q.size() == 0) begin
               $error("unexpected beat: magnitude_bits actual %h", rsp_magnitude_bits);
               errors++;
            end else begin
               logic [31:0] exp_mag;
               exp_mag = magnitude_q.pop_front();
               if (exp_mag !== rsp_magnitude_bits) begin
                  $error("magnitude_bits expected %h actual %h", exp_mag,
                         rsp_magnitude_bits);
                  errors++;
               end
            end
         end
      end
   end

endmodule

// ----- dv/tb_fft_bin_magnitude_fast_rsqrt_unit.sv -----
// Testbench top for the FFT bin magnitude unit: clock, reset, request stimulus
// and verdict. Depends on rsq_pkg, the DUT and the checker module.
module tb_fft_bin_magnitude_fast_rsqrt_unit;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_packed_bin;
   logic        rsp_valid;
   logic [31:0] rsp_magnitude_bits;
   int          errors;
   int          pending;
   int          stall_cnt;
   bit          allow_idle;

   localparam int STALL_LIMIT = 2000;

   fft_bin_magnitude_fast_rsqrt_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_packed_bin(req_packed_bin), .rsp_valid(rsp_valid),
      .rsp_magnitude_bits(rsp_magnitude_bits)
   );

   fft_bin_magnitude_fast_rsqrt_unit_checker u_chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_packed_bin(req_packed_bin), .rsp_valid(rsp_valid),
      .rsp_magnitude_bits(rsp_magnitude_bits), .errors(errors), .pending(pending)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // drive one bin beat, with a random idle gap first
   task automatic send_bin(input logic [31:0] w);
      while (allow_idle && $urandom_range(99) < 37) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_packed_bin <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [31:0] random_bin();
      logic [15:0] re, im;
      re = 16'($urandom);
      im = 16'($urandom);
      case ($urandom_range(3))
         0: re = 16'($signed(re) >>> $urandom_range(15));
         1: im = 16'($signed(im) >>> $urandom_range(15));
         2: begin
            re = 16'($signed(re) >>> $urandom_range(15));
            im = 16'($signed(im) >>> $urandom_range(15));
         end
         default: ;
      endcase
      return {im, re};
   endfunction

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
         $display("tb_fft_bin_magnitude_fast_rsqrt_unit failed");
         $finish;
      end
   end

   initial begin
      logic [31:0] corner[$];
      allow_idle     = 1'b1;
      reset          = 1'b1;
      start          = 1'b0;
      req_packed_bin = 32'd0;
      corner = '{32'h0000_0000, 32'h8000_8000, 32'h7fff_7fff, 32'h0000_7fff,
                 32'h7fff_0000, 32'h8000_0000, 32'h0000_8000, 32'h8000_7fff,
                 32'hffff_ffff, 32'h0000_0001, 32'h0001_0000, 32'h0001_0001,
                 32'hffff_0000, 32'h0003_0004, 32'hfffd_fffc, 32'h5555_aaaa,
                 32'haaaa_5555, 32'h0100_0100, 32'h7fff_8001, 32'h0002_0000};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (corner[i]) send_bin(corner[i]);
      // drain fully before the random part
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      for (int n = 0; n < 1750; n++) begin
         allow_idle = !(n >= 600 && n < 900);
         send_bin(random_bin());
      end
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (rsq_pkg::LATENCY + 10) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("tb_fft_bin_magnitude_fast_rsqrt_unit passed");
      else
         $display("tb_fft_bin_magnitude_fast_rsqrt_unit failed");
      $finish;
   end

endmodule
